FILE: sv/dpr_pkg.sv
package dpr_pkg;

  localparam int FB_WIDTH   = 1024;
  localparam int FB_HEIGHT  = 512;
  localparam int ROW_STRIDE = 2048;
  localparam int FRAC_BITS  = 16;

  localparam int XW = 10;
  localparam int YW = 9;
  localparam int CW = 24;
  localparam int AW = 21;
  localparam int NUMW = XW + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 2;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]    op;
    logic [XW-1:0] vx;
    logic [YW-1:0] vy;
    logic [CW-1:0] color;
  } item_t;

  typedef struct packed {
    logic          pixel_valid;
    logic [XW-1:0] pixel_x;
    logic [YW-1:0] pixel_y;
    logic [AW-1:0] byte_address;
    logic [CW-1:0] pixel_color;
    logic          segment_done;
    logic          refused;
  } res_t;

  function automatic logic [XW-1:0] clamp_x(input logic [XW-1:0] v);
    clamp_x = (32'(v) > FB_WIDTH - 1) ? XW'(FB_WIDTH - 1) : v;
  endfunction

  function automatic logic [YW-1:0] clamp_y(input logic [YW-1:0] v);
    clamp_y = (32'(v) > FB_HEIGHT - 1) ? YW'(FB_HEIGHT - 1) : v;
  endfunction

endpackage

FILE: sv/dpr_fifo.sv
module dpr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dpr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dpr_pkg::item_t head_item
);
  import dpr_pkg::*;

  item_t      mem [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");
`endif

endmodule

FILE: sv/dpr_div.sv
module dpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dpr_pkg::NUMW-1:0]  num_a,
  input  logic [dpr_pkg::NUMW-1:0]  num_b,
  input  logic [dpr_pkg::XW-1:0]    den,
  output logic                      done,
  output logic [dpr_pkg::QW-1:0]    q_a,
  output logic [dpr_pkg::QW-1:0]    q_b
);
  import dpr_pkg::*;

  localparam int CNTW = $clog2(NUMW);

  logic [NUMW-1:0] na_r, na_nxt, nb_r, nb_nxt;
  logic [XW-1:0]   ra_r, ra_nxt, rb_r, rb_nxt, den_r;
  logic [XW:0]     ta, tb;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt, done_r, done_nxt;

  assign done = done_r;
  assign q_a  = na_r[QW-1:0];
  assign q_b  = nb_r[QW-1:0];

  always_comb begin
    ta       = {ra_r, na_r[NUMW-1]};
    tb       = {rb_r, nb_r[NUMW-1]};
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      na_nxt  = num_a;
      nb_nxt  = num_b;
      ra_nxt  = '0;
      rb_nxt  = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (ta >= {1'b0, den_r}) begin
        ra_nxt = XW'(ta - {1'b0, den_r});
        na_nxt = {na_r[NUMW-2:0], 1'b1};
      end else begin
        ra_nxt = ta[XW-1:0];
        na_nxt = {na_r[NUMW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_r}) begin
        rb_nxt = XW'(tb - {1'b0, den_r});
        nb_nxt = {nb_r[NUMW-2:0], 1'b1};
      end else begin
        rb_nxt = tb[XW-1:0];
        nb_nxt = {nb_r[NUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NUMW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    na_r <= na_nxt;
    nb_r <= nb_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while running");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("spurious divider done");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> ra_r < den_r && rb_r < den_r) else $error("remainder out of range");
`endif

endmodule

FILE: sv/dpr_engine.sv
module dpr_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  dpr_pkg::item_t head_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output dpr_pkg::res_t  out_res
);
  import dpr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [XW-1:0] pen_x_r, pen_x_nxt, end_x_r, end_x_nxt;
  logic [YW-1:0] pen_y_r, pen_y_nxt, end_y_r, end_y_nxt;
  logic [31:0]   accum_x_r, accum_x_nxt, accum_y_r, accum_y_nxt;
  logic [SW-1:0] step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [CW-1:0] color_r, color_nxt;
  logic          active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  logic          out_free, div_start, div_done;
  logic [XW:0]   dx, dy;
  logic [XW-1:0] ax, ay, dmax;
  logic [QW-1:0] q_a, q_b;
  logic [15:0]   cx, cy;
  logic [31:0]   tx, ty;
  logic [AW-1:0] addr;

  dpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_a ({ax, FRAC_BITS'(0)}),
    .num_b ({ay, FRAC_BITS'(0)}),
    .den   (dmax),
    .done  (div_done),
    .q_a   (q_a),
    .q_b   (q_b)
  );

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    dx        = {1'b0, head_item.vx} - {1'b0, pen_x_r};
    dy        = {2'b0, head_item.vy} - {2'b0, pen_y_r};
    ax        = dx[XW] ? XW'(-dx) : dx[XW-1:0];
    ay        = dy[XW] ? XW'(-dy) : dy[XW-1:0];
    dmax      = (ax > ay) ? ax : ay;
    cx        = accum_x_r[31:16];
    cy        = accum_y_r[31:16];
    tx        = (cx != 16'(end_x_r)) ? accum_x_r + 32'(signed'(step_x_r)) : accum_x_r;
    ty        = (cy != 16'(end_y_r)) ? accum_y_r + 32'(signed'(step_y_r)) : accum_y_r;
    addr      = AW'({cy, {$clog2(ROW_STRIDE){1'b0}}}) + AW'({cx, 1'b0}) + AW'(cx);
    div_start = (state_r == ST_IDLE) && head_valid && (head_item.op == OP_NEXT)
                && !active_r && (dmax != '0);

    state_nxt     = state_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    end_x_nxt     = end_x_r;
    end_y_nxt     = end_y_r;
    accum_x_nxt   = accum_x_r;
    accum_y_nxt   = accum_y_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    color_nxt     = color_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    pop           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else if (head_valid && out_free) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          if (head_item.op == OP_START || head_item.op == OP_NEXT) begin
            if (active_r) begin
              res_nxt.refused = 1'b1;
            end else begin
              pen_x_nxt = head_item.vx;
              pen_y_nxt = head_item.vy;
            end
            res_nxt.segment_done = !active_r;
          end else if (head_item.op == OP_TICK && active_r) begin
            res_nxt.pixel_valid  = 1'b1;
            res_nxt.pixel_x      = cx[XW-1:0];
            res_nxt.pixel_y      = cy[YW-1:0];
            res_nxt.byte_address = addr;
            res_nxt.pixel_color  = color_r;
            accum_x_nxt = tx;
            accum_y_nxt = ty;
            if (tx[31:16] == 16'(end_x_r) && ty[31:16] == 16'(end_y_r)) begin
              active_nxt           = 1'b0;
              res_nxt.segment_done = 1'b1;
            end
          end else begin
            res_nxt.segment_done = !active_r;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_x_nxt = dx[XW] ? SW'(-{1'b0, q_a}) : SW'(q_a);
          step_y_nxt = dy[XW] ? SW'(-{1'b0, q_b}) : SW'(q_b);
          state_nxt  = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          pop           = 1'b1;
          accum_x_nxt   = {6'b0, pen_x_r, 16'h8000};
          accum_y_nxt   = {7'b0, pen_y_r, 16'h8000};
          end_x_nxt     = head_item.vx;
          end_y_nxt     = head_item.vy;
          pen_x_nxt     = head_item.vx;
          pen_y_nxt     = head_item.vy;
          color_nxt     = head_item.color;
          active_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      accum_x_r   <= '0;
      accum_y_r   <= '0;
      step_x_r    <= '0;
      step_y_r    <= '0;
      color_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      end_x_r     <= end_x_nxt;
      end_y_r     <= end_y_nxt;
      accum_x_r   <= accum_x_nxt;
      accum_y_r   <= accum_y_nxt;
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      color_r     <= color_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> out_free) else $error("result overwritten");
  a_refuse_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.refused |-> !res_r.pixel_valid) else $error("refused pixel");
  a_div_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !active_r) else $error("setup during segment");
  a_commit_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && pop) |=> active_r) else $error("segment not opened");
`endif

endmodule

FILE: sv/dda_polyline_rasterizer.sv
// Polyline rasteriser on a 16.16 fixed-point DDA. Transactions enter a two-deep
// queue and are executed in order, one result transaction each. Ticks, start
// vertices, refused vertices and zero-length segments need no divider, so a
// segment is drawn at one pixel per cycle while ticks arrive and the output is
// not stalled. A next-vertex transaction opening a segment starts the bit-serial
// divider, which forms both axis steps together, then loads the steps and opens
// the segment. Vertices are clamped to the frame as they enter the queue.
module dda_polyline_rasterizer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [dpr_pkg::XW-1:0]  in_vertex_x,
  input  logic [dpr_pkg::YW-1:0]  in_vertex_y,
  input  logic [dpr_pkg::CW-1:0]  in_line_color,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_pixel_valid,
  output logic [dpr_pkg::XW-1:0]  out_pixel_x,
  output logic [dpr_pkg::YW-1:0]  out_pixel_y,
  output logic [dpr_pkg::AW-1:0]  out_byte_address,
  output logic [dpr_pkg::CW-1:0]  out_pixel_color,
  output logic                    out_segment_done,
  output logic                    out_refused
);
  import dpr_pkg::*;

  item_t in_item, head_item;
  res_t  res;
  logic  full, push, pop, head_valid;

  assign in_item.op    = in_operation;
  assign in_item.vx    = clamp_x(in_vertex_x);
  assign in_item.vy    = clamp_y(in_vertex_y);
  assign in_item.color = in_line_color;
  assign in_stall      = full;
  assign push          = in_valid && !full;

  dpr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (in_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dpr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_pixel_valid  = res.pixel_valid;
  assign out_pixel_x      = res.pixel_x;
  assign out_pixel_y      = res.pixel_y;
  assign out_byte_address = res.byte_address;
  assign out_pixel_color  = res.pixel_color;
  assign out_segment_done = res.segment_done;
  assign out_refused      = res.refused;

endmodule

FILE: test/tb_dda_polyline_rasterizer.sv
`timescale 1ns / 1ps
module tb_dda_polyline_rasterizer;
  import dpr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = OP_START;
  logic [XW-1:0] in_vertex_x = '0;
  logic [YW-1:0] in_vertex_y = '0;
  logic [CW-1:0] in_line_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_pixel_valid;
  logic [XW-1:0] out_pixel_x;
  logic [YW-1:0] out_pixel_y;
  logic [AW-1:0] out_byte_address;
  logic [CW-1:0] out_pixel_color;
  logic out_segment_done;
  logic out_refused;

  dda_polyline_rasterizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y), .in_line_color(in_line_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_valid(out_pixel_valid), .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y), .out_byte_address(out_byte_address),
    .out_pixel_color(out_pixel_color), .out_segment_done(out_segment_done),
    .out_refused(out_refused)
  );

  always #5 clk = ~clk;

  item_t pending_items[$];
  res_t expected_pixels[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int pixels_seen = 0;
  int refusals_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_sink = 1'b0;
  bit pause_send = 1'b0;

  logic [XW-1:0] pen_x = '0, end_x = '0;
  logic [YW-1:0] pen_y = '0, end_y = '0;
  logic [31:0] acc_x = '0, acc_y = '0;
  logic signed [31:0] stp_x = '0, stp_y = '0;
  logic [CW-1:0] seg_color = '0;
  bit seg_active;

  function automatic res_t raster_step(item_t it);
    res_t r;
    logic [XW-1:0] vx;
    logic [YW-1:0] vy;
    int dx, dy, ax, ay, dv;
    int unsigned cx, cy;
    r = '0;
    vx = (it.vx > FB_WIDTH - 1) ? XW'(FB_WIDTH - 1) : it.vx;
    vy = (it.vy > FB_HEIGHT - 1) ? YW'(FB_HEIGHT - 1) : it.vy;
    if (it.op == OP_START || it.op == OP_NEXT) begin
      if (seg_active) begin
        r.refused = 1'b1;
      end else if (it.op == OP_START) begin
        pen_x = vx;
        pen_y = vy;
      end else begin
        dx = int'(vx) - int'(pen_x);
        dy = int'(vy) - int'(pen_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        dv = ax > ay ? ax : ay;
        if (dv != 0) begin
          stp_x = (dx * 65536) / dv;
          stp_y = (dy * 65536) / dv;
          acc_x = (32'(pen_x) << FRAC_BITS) + 32'h8000;
          acc_y = (32'(pen_y) << FRAC_BITS) + 32'h8000;
          end_x = vx;
          end_y = vy;
          seg_color = it.color;
          seg_active = 1'b1;
        end
        pen_x = vx;
        pen_y = vy;
      end
      r.segment_done = !seg_active;
    end else if (it.op == OP_TICK) begin
      if (seg_active) begin
        cx = acc_x >> FRAC_BITS;
        cy = acc_y >> FRAC_BITS;
        r.pixel_valid = 1'b1;
        r.pixel_x = cx[XW-1:0];
        r.pixel_y = cy[YW-1:0];
        r.byte_address = AW'(cy * ROW_STRIDE + cx * 3);
        r.pixel_color = seg_color;
        if (cx != end_x) acc_x = acc_x + stp_x;
        if (cy != end_y) acc_y = acc_y + stp_y;
        if ((acc_x >> FRAC_BITS) == end_x && (acc_y >> FRAC_BITS) == end_y) begin
          seg_active = 1'b0;
          r.segment_done = 1'b1;
        end
      end else begin
        r.segment_done = 1'b1;
      end
    end else begin
      r.segment_done = !seg_active;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_pixels.push_back(raster_step('{in_operation, in_vertex_x,
                                              in_vertex_y, in_line_color}));
      sent <= sent + 1;
    end
    if (!rst_n || (in_valid && in_stall)) begin
    end else if (pending_items.size() > 0 && !pause_send &&
                 $urandom_range(99) >= send_idle_pct) begin
      item_t nx;
      nx = pending_items.pop_front();
      in_valid <= 1'b1;
      in_operation <= nx.op;
      in_vertex_x <= nx.vx;
      in_vertex_y <= nx.vy;
      in_line_color <= nx.color;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      res_t got, exp_r;
      got = '{out_pixel_valid, out_pixel_x, out_pixel_y, out_byte_address,
              out_pixel_color, out_segment_done, out_refused};
      received <= received + 1;
      if (got.pixel_valid) pixels_seen <= pixels_seen + 1;
      if (got.refused) refusals_seen <= refusals_seen + 1;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, got);
        errors <= errors + 1;
      end else begin
        exp_r = expected_pixels.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
          errors <= errors + 1;
        end
      end
    end
    out_stall <= hold_sink || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic add_item(logic [1:0] op, int x, int y, int c);
    pending_items.push_back('{op, XW'(x), YW'(y), CW'(c)});
  endtask

  task automatic add_random_polyline();
    int n;
    add_item(OP_START, $urandom_range(1023), $urandom_range(511), $urandom);
    n = $urandom_range(3, 1);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        add_item(OP_NEXT, $urandom_range(1023), $urandom_range(511), $urandom);
      end else begin
        add_item(OP_NEXT, $urandom_range(1023) % 40 + (($urandom_range(1) ? 0 : 980)),
                 $urandom_range(511) % 30 + (($urandom_range(1) ? 0 : 480)), $urandom);
      end
      repeat ($urandom_range(45, 0)) add_item(OP_TICK, $urandom, $urandom, $urandom);
      if ($urandom_range(7) == 0) add_item($urandom_range(3), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    add_item(OP_TICK, 0, 0, 0);
    add_item(OP_NEXT, 0, 0, 24'hFFFFFF);
    add_item(OP_START, 1023, 511, 0);
    add_item(OP_NEXT, 1020, 509, 24'hA5A5A5);
    add_item(OP_START, 5, 5, 0);
    add_item(3, 1023, 511, 24'hFFFFFF);
    repeat (3) add_item(OP_TICK, 0, 0, 0);
    add_item(OP_NEXT, 1023, 511, 24'h123456);
    add_item(OP_START, 0, 0, 24'hFFFFFF);
    repeat (6) add_item(OP_TICK, 0, 0, 0);
    add_item(OP_START, 1010, 500, 0);
    add_item(OP_NEXT, 1000, 498, 24'h5A5A5A);
    repeat (4) add_item(OP_TICK, 1023, 511, 24'hFFFFFF);
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 14) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 52 : 14) : 0;
      while (pending_items.size() < 230) add_random_polyline();
      if (ph == 2) begin
        hold_sink = 1'b1;
        repeat (150) @(posedge clk);
        hold_sink = 1'b0;
      end
      if (ph == 1) begin
        repeat (100) @(posedge clk);
        pause_send = 1'b1;
        while (expected_pixels.size() > 0 || in_valid) @(posedge clk);
        pause_send = 1'b0;
      end
      drain();
    end
    $display("Covered %0d transactions with %0d pixels and %0d refused vertices,",
             received, pixels_seen, refusals_seen);
    $display("over phases of free flow, sender gaps, sink stalls and both.");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
sv/dpr_pkg.sv
sv/dpr_fifo.sv
sv/dpr_div.sv
sv/dpr_engine.sv
sv/dda_polyline_rasterizer.sv
test/tb_dda_polyline_rasterizer.sv
